>>> rtl/mhsi_pkg.sv
// mhsi_pkg: shared widths, reset constants, state type and divider interface
// for the magnetometer hard/soft-iron calibration core; no dependencies
package mhsi_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SCALE_FRAC_BITS = 12;
    localparam int SCALE_W         = 16;
    localparam int CFG_W           = 16;
    localparam int NUM_AXES        = 3;
    localparam int AXIS_W          = 2;

    localparam int OFFSET_W = SAMPLE_BITS + 1;
    localparam int RANGE_W  = SAMPLE_BITS + 1;
    localparam int SUM_W    = RANGE_W + 2;
    localparam int DEN_W    = RANGE_W + 3;
    localparam int NUM_W    = SUM_W + SCALE_FRAC_BITS + 2;
    localparam int CNT_W    = $clog2(NUM_W);

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);
    localparam logic [CNT_W-1:0]  DIV_STEPS_M1 = CNT_W'(NUM_W - 1);

    localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

    localparam logic [SCALE_W-1:0] SCALE_INIT_X =
        SCALE_W'(((937 << SCALE_FRAC_BITS) + 500) / 1000);
    localparam logic [SCALE_W-1:0] SCALE_INIT_Y =
        SCALE_W'(((1030 << SCALE_FRAC_BITS) + 500) / 1000);
    localparam logic [SCALE_W-1:0] SCALE_INIT_Z =
        SCALE_W'(((1010 << SCALE_FRAC_BITS) + 500) / 1000);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LOW  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_HIGH = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [2:0] {
        ST_TRACK,
        ST_SETUP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [SCALE_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> rtl/mhsi_track.sv
// mhsi_track: running maximum and minimum of one axis
// depends on mhsi_pkg
module mhsi_track (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_restart,
    input  mhsi_pkg::t_sample i_sample,
    output mhsi_pkg::t_sample o_max,
    output mhsi_pkg::t_sample o_min
);

    mhsi_pkg::t_sample r_max, n_max;
    mhsi_pkg::t_sample r_min, n_min;

    always_comb begin
        n_max = r_max;
        n_min = r_min;
        if (i_restart) begin
            n_max = mhsi_pkg::SAMPLE_LOW;
            n_min = mhsi_pkg::SAMPLE_HIGH;
        end else if (i_en) begin
            if (i_sample > r_max) begin
                n_max = i_sample;
            end
            if (i_sample < r_min) begin
                n_min = i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= mhsi_pkg::SAMPLE_LOW;
            r_min <= mhsi_pkg::SAMPLE_HIGH;
        end else begin
            r_max <= n_max;
            r_min <= n_min;
        end
    end

    assign o_max = r_max;
    assign o_min = r_min;

endmodule

>>> rtl/mhsi_div.sv
// mhsi_div: bit-serial restoring divider, one quotient bit per cycle,
// quotient saturated to the scale width; depends on mhsi_pkg
module mhsi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mhsi_pkg::t_div_req i_req,
    output mhsi_pkg::t_div_rsp o_rsp
);

    logic [mhsi_pkg::NUM_W-1:0]   r_num, n_num;
    logic [mhsi_pkg::DEN_W-1:0]   r_den, n_den;
    logic [mhsi_pkg::DEN_W-1:0]   r_rem, n_rem;
    logic [mhsi_pkg::SCALE_W-1:0] r_quo, n_quo;
    logic                         r_ovf, n_ovf;
    logic [mhsi_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_busy, n_busy;
    logic                         r_done, n_done;

    logic [mhsi_pkg::DEN_W:0] w_rem_sh;
    logic [mhsi_pkg::DEN_W:0] w_diff;
    logic                     w_ge;

    assign w_rem_sh = {r_rem, r_num[mhsi_pkg::NUM_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    always_comb begin
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_ovf  = r_ovf;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (r_busy) begin
            n_num = {r_num[mhsi_pkg::NUM_W-2:0], 1'b0};
            n_rem = w_ge ? w_diff[mhsi_pkg::DEN_W-1:0] : w_rem_sh[mhsi_pkg::DEN_W-1:0];
            n_quo = {r_quo[mhsi_pkg::SCALE_W-2:0], w_ge};
            n_ovf = r_ovf | r_quo[mhsi_pkg::SCALE_W-1];
            n_cnt = r_cnt - mhsi_pkg::CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_num  = i_req.num;
            n_den  = i_req.den;
            n_rem  = '0;
            n_quo  = '0;
            n_ovf  = 1'b0;
            n_cnt  = mhsi_pkg::DIV_STEPS_M1;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_ovf <= n_ovf;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_ovf ? mhsi_pkg::SCALE_MAX : r_quo;

endmodule

>>> rtl/mag_hard_soft_iron_calibration_core.sv
// mag_hard_soft_iron_calibration_core: per-axis min/max tracking, offsets and
// soft-iron scales; depends on mhsi_pkg, mhsi_track, mhsi_div
// an ordinary word updates the min/max trackers; a last-sample word gives its result once
// the bit-serial divider (NUM_W = 33 steps per axis) has run for each axis above min_range
// throughput: 1 word per cycle between last samples, none until their result is registered
// reset: synchronous active low, restores trackers, scales and min_range at once
module mag_hard_soft_iron_calibration_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [mhsi_pkg::SAMPLE_BITS-1:0] i_mag_x,
    input  logic signed [mhsi_pkg::SAMPLE_BITS-1:0] i_mag_y,
    input  logic signed [mhsi_pkg::SAMPLE_BITS-1:0] i_mag_z,
    input  logic                                i_last_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mhsi_pkg::OFFSET_W-1:0] o_offset_x,
    output logic signed [mhsi_pkg::OFFSET_W-1:0] o_offset_y,
    output logic signed [mhsi_pkg::OFFSET_W-1:0] o_offset_z,
    output logic [mhsi_pkg::SCALE_W-1:0]        o_scale_x,
    output logic [mhsi_pkg::SCALE_W-1:0]        o_scale_y,
    output logic [mhsi_pkg::SCALE_W-1:0]        o_scale_z,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mhsi_pkg::CFG_W-1:0]          i_min_range
);

    mhsi_pkg::t_state r_state, n_state;
    logic [mhsi_pkg::AXIS_W-1:0] r_axis, n_axis;

    logic [mhsi_pkg::CFG_W-1:0]    r_min_range;
    logic [mhsi_pkg::SCALE_W-1:0]  r_scale [mhsi_pkg::NUM_AXES];
    logic [mhsi_pkg::RANGE_W-1:0]  r_range [mhsi_pkg::NUM_AXES];
    logic signed [mhsi_pkg::OFFSET_W-1:0] r_offset [mhsi_pkg::NUM_AXES];
    logic [mhsi_pkg::NUM_AXES-1:0] r_upd;
    logic [mhsi_pkg::SUM_W-1:0]    r_sum;

    logic                          r_out_valid;
    logic signed [mhsi_pkg::OFFSET_W-1:0] r_out_offset [mhsi_pkg::NUM_AXES];
    logic [mhsi_pkg::SCALE_W-1:0]  r_out_scale [mhsi_pkg::NUM_AXES];

    mhsi_pkg::t_sample w_sample [mhsi_pkg::NUM_AXES];
    mhsi_pkg::t_sample w_max [mhsi_pkg::NUM_AXES];
    mhsi_pkg::t_sample w_min [mhsi_pkg::NUM_AXES];
    logic [mhsi_pkg::RANGE_W-1:0]  w_range [mhsi_pkg::NUM_AXES];
    logic signed [mhsi_pkg::OFFSET_W-1:0] w_offset [mhsi_pkg::NUM_AXES];
    logic [mhsi_pkg::SUM_W-1:0]    w_sum;

    logic                          w_accept;
    logic                          w_restart;
    logic                          w_out_free;
    logic                          w_div_start;
    logic [mhsi_pkg::RANGE_W+1:0]  w_r3;
    mhsi_pkg::t_div_req            w_div_req;
    mhsi_pkg::t_div_rsp            w_div_rsp;

    assign w_sample[0] = i_mag_x;
    assign w_sample[1] = i_mag_y;
    assign w_sample[2] = i_mag_z;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    for (genvar a = 0; a < mhsi_pkg::NUM_AXES; a++) begin : g_axis
        mhsi_track u_track (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_accept),
            .i_restart (w_restart),
            .i_sample  (w_sample[a]),
            .o_max     (w_max[a]),
            .o_min     (w_min[a])
        );

        assign w_range[a] = mhsi_pkg::RANGE_W'({w_max[a][mhsi_pkg::SAMPLE_BITS-1], w_max[a]}
                          - {w_min[a][mhsi_pkg::SAMPLE_BITS-1], w_min[a]});
        assign w_offset[a] = {w_max[a][mhsi_pkg::SAMPLE_BITS-1], w_max[a]}
                           + {w_min[a][mhsi_pkg::SAMPLE_BITS-1], w_min[a]};
    end

    assign w_sum = mhsi_pkg::SUM_W'(w_range[0]) + mhsi_pkg::SUM_W'(w_range[1])
                 + mhsi_pkg::SUM_W'(w_range[2]);

    // 3 * range of the axis being divided
    assign w_r3 = {1'b0, r_range[r_axis], 1'b0} + (mhsi_pkg::RANGE_W+2)'(r_range[r_axis]);

    always_comb begin
        w_div_req.start = w_div_start;
        w_div_req.num   = mhsi_pkg::NUM_W'({r_sum, {(mhsi_pkg::SCALE_FRAC_BITS+1){1'b0}}})
                        + mhsi_pkg::NUM_W'(w_r3);
        w_div_req.den   = {w_r3, 1'b0};
    end

    mhsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        case (r_state)
            mhsi_pkg::ST_TRACK: begin
                if (w_accept && i_last_sample) begin
                    n_state = mhsi_pkg::ST_SETUP;
                end
            end
            mhsi_pkg::ST_SETUP: begin
                n_state = mhsi_pkg::ST_DIV_START;
                n_axis  = '0;
            end
            mhsi_pkg::ST_DIV_START: begin
                if (r_upd[r_axis]) begin
                    n_state = mhsi_pkg::ST_DIV_WAIT;
                end else if (r_axis == mhsi_pkg::LAST_AXIS) begin
                    n_state = mhsi_pkg::ST_DONE;
                end else begin
                    n_axis = r_axis + mhsi_pkg::AXIS_W'(1);
                end
            end
            mhsi_pkg::ST_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    if (r_axis == mhsi_pkg::LAST_AXIS) begin
                        n_state = mhsi_pkg::ST_DONE;
                    end else begin
                        n_state = mhsi_pkg::ST_DIV_START;
                        n_axis  = r_axis + mhsi_pkg::AXIS_W'(1);
                    end
                end
            end
            mhsi_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = mhsi_pkg::ST_TRACK;
                end
            end
            default: begin
                n_state = mhsi_pkg::ST_TRACK;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready  = 1'b0;
        w_restart   = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            mhsi_pkg::ST_TRACK: begin
                o_in_ready = 1'b1;
            end
            mhsi_pkg::ST_SETUP: begin
                w_restart = 1'b1;
            end
            mhsi_pkg::ST_DIV_START: begin
                w_div_start = r_upd[r_axis];
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhsi_pkg::ST_TRACK;
            r_axis      <= '0;
            r_min_range <= '0;
            r_out_valid <= 1'b0;
            r_scale[0]  <= mhsi_pkg::SCALE_INIT_X;
            r_scale[1]  <= mhsi_pkg::SCALE_INIT_Y;
            r_scale[2]  <= mhsi_pkg::SCALE_INIT_Z;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_range <= i_min_range;
            end
            if (r_state == mhsi_pkg::ST_DIV_WAIT && w_div_rsp.done) begin
                r_scale[r_axis] <= w_div_rsp.quot;
            end
            if (r_state == mhsi_pkg::ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mhsi_pkg::ST_SETUP) begin
            r_sum <= w_sum;
            for (int a = 0; a < mhsi_pkg::NUM_AXES; a++) begin
                r_range[a]  <= w_range[a];
                r_offset[a] <= w_offset[a];
                r_upd[a]    <= w_range[a] > mhsi_pkg::RANGE_W'(r_min_range);
            end
        end
        if (r_state == mhsi_pkg::ST_DONE && w_out_free) begin
            for (int a = 0; a < mhsi_pkg::NUM_AXES; a++) begin
                r_out_offset[a] <= r_offset[a];
                r_out_scale[a]  <= r_scale[a];
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_offset_x  = r_out_offset[0];
    assign o_offset_y  = r_out_offset[1];
    assign o_offset_z  = r_out_offset[2];
    assign o_scale_x   = r_out_scale[0];
    assign o_scale_y   = r_out_scale[1];
    assign o_scale_z   = r_out_scale[2];

endmodule
